>>> design/qcsv_pkg.sv
package qcsv_pkg;

	localparam int unsigned LINE_BITS_DEF = 24;
	localparam int unsigned LINE_OUT_W    = 24;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef enum logic [1:0] {
		ST_BETWEEN = 2'd0,
		ST_INSIDE  = 2'd1,
		ST_QUOTE   = 2'd2,
		ST_ERROR   = 2'd3
	} parse_state_t;

	typedef enum logic [2:0] {
		TK_BYTE     = 3'd0,
		TK_CELL     = 3'd1,
		TK_ROW      = 3'd2,
		TK_CELL_ROW = 3'd3,
		TK_ERROR    = 3'd4
	} token_kind_t;

	// Decision taken for one byte: whether a token leaves, what it carries, and the
	// state left behind.
	typedef struct packed {
		logic         emit;
		token_kind_t  kind;
		logic [7:0]   data;
		parse_state_t state;
	} step_t;

endpackage

>>> design/qcsv_step.sv
module qcsv_step
	import qcsv_pkg::*;
#(
	parameter int unsigned LINE_BITS = LINE_BITS_DEF
) (
	input  parse_state_t         state,
	input  logic [LINE_BITS-1:0] line,
	input  logic [7:0]           byte_cur,
	output step_t                step,
	output logic [LINE_BITS-1:0] line_next
);

	logic is_lf;

	assign is_lf = (byte_cur == CH_LF);

	// Count every newline outside the error state, saturating at all ones.
	always_comb begin
		line_next = line;
		if (state != ST_ERROR && is_lf && line != {LINE_BITS{1'b1}}) begin
			line_next = LINE_BITS'(line + 1'b1);
		end
	end

	// Next state.
	always_comb begin
		step.state = state;
		case (state)
			ST_BETWEEN: begin
				if (byte_cur == CH_QUOTE) begin
					step.state = ST_INSIDE;
				end else if (byte_cur != CH_CR && byte_cur != CH_LF) begin
					step.state = ST_ERROR;
				end
			end
			ST_INSIDE: begin
				if (byte_cur == CH_QUOTE) begin
					step.state = ST_QUOTE;
				end
			end
			ST_QUOTE: begin
				if (byte_cur == CH_QUOTE) begin
					step.state = ST_INSIDE;
				end else if (byte_cur == CH_COMMA || byte_cur == CH_LF) begin
					step.state = ST_BETWEEN;
				end else if (byte_cur != CH_CR) begin
					step.state = ST_ERROR;
				end
			end
			ST_ERROR: begin
				step.state = ST_ERROR;
			end
			default: begin
				step.state = ST_ERROR;
			end
		endcase
	end

	// Token outputs.
	always_comb begin
		step.emit = 1'b0;
		step.kind = TK_ERROR;
		step.data = 8'h00;
		case (state)
			ST_BETWEEN: begin
				if (byte_cur == CH_LF) begin
					step.emit = 1'b1;
					step.kind = TK_ROW;
				end else if (byte_cur != CH_QUOTE && byte_cur != CH_CR) begin
					step.emit = 1'b1;
					step.kind = TK_ERROR;
				end
			end
			ST_INSIDE: begin
				if (byte_cur != CH_QUOTE) begin
					step.emit = 1'b1;
					step.kind = TK_BYTE;
					step.data = byte_cur;
				end
			end
			ST_QUOTE: begin
				if (byte_cur == CH_QUOTE) begin
					step.emit = 1'b1;
					step.kind = TK_BYTE;
					step.data = CH_QUOTE;
				end else if (byte_cur == CH_COMMA) begin
					step.emit = 1'b1;
					step.kind = TK_CELL;
				end else if (byte_cur == CH_LF) begin
					step.emit = 1'b1;
					step.kind = TK_CELL_ROW;
				end else if (byte_cur != CH_CR) begin
					step.emit = 1'b1;
					step.kind = TK_ERROR;
				end
			end
			ST_ERROR: begin
				step.emit = 1'b1;
				step.kind = TK_ERROR;
			end
			default: begin
				step.emit = 1'b1;
				step.kind = TK_ERROR;
			end
		endcase
	end

endmodule

>>> design/quoted_csv_tokenizer_unit.sv
// Channel  | Direction | Handshake                 | Payload
// byte     | in        | byte_valid / byte_ready   | byte_in[7:0]
// token    | out       | token_valid / token_ready | token_kind[2:0], cell_byte[7:0],
//          |           |                           | line_number[23:0]
//
// One byte beat per cycle sustained while tokens drain; a token is decoded from the input register,
// then loaded into the token register, from which it leaves.
// Parse state and line counter advance as the registered byte is decoded, with no bubble.
// A stalled token register holds the next token-bearing byte in the input register;
// a byte that yields no token passes through even while the token register is full.
// Reset clears both valid flags, sets the state to between cells and the line to 1.
module quoted_csv_tokenizer_unit
	import qcsv_pkg::*;
#(
	parameter int unsigned LINE_BITS = LINE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  logic [7:0]            byte_in,
	output logic                  token_valid,
	input  logic                  token_ready,
	output logic [2:0]            token_kind,
	output logic [7:0]            cell_byte,
	output logic [LINE_OUT_W-1:0] line_number
);

	// Input register stage.
	logic                 valid_s1;
	logic [7:0]           byte_s1;

	// Parser state.
	parse_state_t         state_q;
	logic [LINE_BITS-1:0] line_q;

	// Token register.
	logic                  token_valid_q;
	token_kind_t           token_kind_q;
	logic [7:0]            cell_byte_q;
	logic [LINE_OUT_W-1:0] line_number_q;

	step_t                step;
	logic [LINE_BITS-1:0] line_next;
	logic [31:0]          line_wide;
	logic                 advance_s1;

	qcsv_step #(
		.LINE_BITS(LINE_BITS)
	) u_step (
		.state    (state_q),
		.line     (line_q),
		.byte_cur (byte_s1),
		.step     (step),
		.line_next(line_next)
	);

	// Retire the registered byte when its token has somewhere to go, or when it
	// makes no token at all.
	assign advance_s1 = valid_s1 && (!step.emit || !token_valid_q || token_ready);
	assign byte_ready = !valid_s1 || advance_s1;

	// Report the low bits of the counter; a narrow counter is zero-extended.
	assign line_wide = 32'(line_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= byte_in;
		end
	end

	// Advance parser state with each decoded byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BETWEEN;
			line_q  <= LINE_BITS'(1);
		end else if (advance_s1) begin
			state_q <= step.state;
			line_q  <= line_next;
		end
	end

	// Load a token as it is decoded; drop the valid flag once it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid_q <= 1'b0;
		end else if (advance_s1 && step.emit) begin
			token_valid_q <= 1'b1;
		end else if (token_ready) begin
			token_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && step.emit) begin
			token_kind_q  <= step.kind;
			cell_byte_q   <= step.data;
			line_number_q <= line_wide[LINE_OUT_W-1:0];
		end
	end

	assign token_valid = token_valid_q;
	assign token_kind  = token_kind_q;
	assign cell_byte   = cell_byte_q;
	assign line_number = line_number_q;

endmodule

>>> design/qcsv_checker.sv
module qcsv_checker
	import qcsv_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  byte_valid,
	input logic                  byte_ready,
	input logic [7:0]            byte_in,
	input logic                  token_valid,
	input logic                  token_ready,
	input logic [2:0]            token_kind,
	input logic [7:0]            cell_byte,
	input logic [LINE_OUT_W-1:0] line_number
);

	logic err_seen_q;

	// Remember that an error beat has been shown.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (token_valid && token_kind == TK_ERROR) begin
			err_seen_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> token_valid && $stable(token_kind)
			&& $stable(cell_byte) && $stable(line_number))
		else $error("token beat changed while stalled");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && err_seen_q |-> token_kind == TK_ERROR)
		else $error("non-error token after an error");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind != TK_BYTE |-> cell_byte == 8'h00)
		else $error("cell byte set on a non-data token");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> token_kind == TK_BYTE || token_kind == TK_CELL
			|| token_kind == TK_ROW || token_kind == TK_CELL_ROW
			|| token_kind == TK_ERROR)
		else $error("token kind out of range");

	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(byte_in))
		else $error("byte beat changed while stalled");

endmodule

bind quoted_csv_tokenizer_unit qcsv_checker u_qcsv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_ready (byte_ready),
	.byte_in    (byte_in),
	.token_valid(token_valid),
	.token_ready(token_ready),
	.token_kind (token_kind),
	.cell_byte  (cell_byte),
	.line_number(line_number)
);

>>> dv/testbench.sv
module testbench
	import qcsv_pkg::*;
;

	// A counter narrower than the line number output, so that the zero-extended line number is exercised.
	localparam int unsigned COUNTER_BITS = 16;
	localparam logic [COUNTER_BITS-1:0] LINE_TOP = '1;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_BEATS = 160;

	typedef struct packed {
		token_kind_t           kind;
		logic [7:0]            data;
		logic [LINE_OUT_W-1:0] line;
	} token_t;

	// One byte beat as queued by the sender; fixed marks a hand-written expectation.
	typedef struct packed {
		logic [7:0] value;
		logic       fixed;
		token_t     tok;
	} byte_note_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_ready;
	logic [7:0]            byte_in = 8'h00;
	logic                  token_valid;
	logic                  token_ready = 1'b0;
	logic [2:0]            token_kind;
	logic [7:0]            cell_byte;
	logic [LINE_OUT_W-1:0] line_number;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned sent_beats = 0;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;

	// Predictor state: where the parser stands and which line it is on.
	parse_state_t            csv_state = ST_BETWEEN;
	logic [COUNTER_BITS-1:0] cur_line = 1;

	byte_note_t byte_notes[$];
	token_t     pending_tokens[$];

	// Opening table: well-formed text only, since an error would stick for the rest of the run.
	byte_note_t directed_rows [24] = '{
		'{CH_LF,    1'b1, '{TK_ROW,      8'h00, 24'd2}},	// empty row straight after reset
		'{CH_CR,    1'b0, '0},				// carriage return between cells
		'{CH_QUOTE, 1'b0, '0},				// open a cell
		'{8'h00,    1'b1, '{TK_BYTE,     8'h00, 24'd2}},
		'{8'hFF,    1'b1, '{TK_BYTE,     8'hFF, 24'd2}},
		'{CH_QUOTE, 1'b0, '0},
		'{CH_QUOTE, 1'b1, '{TK_BYTE,     8'h22, 24'd2}},	// doubled quote
		'{CH_COMMA, 1'b0, '0},				// comma as data
		'{CH_CR,    1'b0, '0},				// carriage return as data
		'{CH_LF,    1'b1, '{TK_BYTE,     8'h0A, 24'd3}},	// newline inside a cell
		'{CH_QUOTE, 1'b0, '0},				// close
		'{CH_CR,    1'b0, '0},				// ignored after the closing quote
		'{CH_COMMA, 1'b1, '{TK_CELL,     8'h00, 24'd3}},
		'{CH_CR,    1'b0, '0},
		'{CH_QUOTE, 1'b0, '0},
		'{CH_QUOTE, 1'b0, '0},				// empty cell
		'{CH_LF,    1'b1, '{TK_CELL_ROW, 8'h00, 24'd4}},
		'{CH_QUOTE, 1'b0, '0},
		'{8'h41,    1'b0, '0},
		'{8'h80,    1'b0, '0},
		'{8'h7F,    1'b0, '0},
		'{CH_QUOTE, 1'b0, '0},
		'{CH_LF,    1'b0, '0},
		'{CH_LF,    1'b1, '{TK_ROW,      8'h00, 24'd6}}
	};

	quoted_csv_tokenizer_unit #(
		.LINE_BITS(COUNTER_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_in(byte_in),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token_kind(token_kind),
		.cell_byte(cell_byte),
		.line_number(line_number)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decode one byte against the predictor state; return 1 when it yields a token.
	function automatic logic tokenize_byte(input logic [7:0] c, output token_t tok);
		logic hit;
		hit = 1'b1;
		tok.kind = TK_ERROR;
		tok.data = 8'h00;
		if (csv_state != ST_ERROR) begin
			// every newline counts, even one inside a cell, before the byte is decoded
			if (c == CH_LF && cur_line != LINE_TOP)
				cur_line = cur_line + 1'b1;
			case (csv_state)
				ST_BETWEEN: begin
					if (c == CH_QUOTE) begin
						csv_state = ST_INSIDE;
						hit = 1'b0;
					end else if (c == CH_CR) begin
						hit = 1'b0;
					end else if (c == CH_LF) begin
						tok.kind = TK_ROW;
					end else begin
						csv_state = ST_ERROR;
					end
				end
				ST_INSIDE: begin
					if (c == CH_QUOTE) begin
						csv_state = ST_QUOTE;
						hit = 1'b0;
					end else begin
						tok.kind = TK_BYTE;
						tok.data = c;
					end
				end
				default: begin
					if (c == CH_QUOTE) begin
						csv_state = ST_INSIDE;
						tok.kind = TK_BYTE;
						tok.data = CH_QUOTE;
					end else if (c == CH_COMMA) begin
						csv_state = ST_BETWEEN;
						tok.kind = TK_CELL;
					end else if (c == CH_CR) begin
						hit = 1'b0;
					end else if (c == CH_LF) begin
						csv_state = ST_BETWEEN;
						tok.kind = TK_CELL_ROW;
					end else begin
						csv_state = ST_ERROR;
					end
				end
			endcase
		end
		tok.line = LINE_OUT_W'(cur_line);
		return hit;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endtask

	// Drive one byte beat; idle first at the current rate, then hold until accepted.
	task automatic drive_byte(input byte_note_t n);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_notes.insert(byte_notes.size(), n);
		byte_valid <= 1'b1;
		byte_in <= n.value;
		do @(posedge clk); while (!byte_ready);
		sent_beats++;
	endtask

	task automatic send_char(input logic [7:0] c);
		byte_note_t n;
		n = '0;
		n.value = c;
		drive_byte(n);
	endtask

	// Cell contents, biased towards the bytes that mean something to the parser.
	task automatic send_content();
		int unsigned len;
		logic [7:0] c;
		len = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(5);
		repeat (len) begin
			case ($urandom_range(9))
				0: c = CH_QUOTE;
				1: c = CH_COMMA;
				2: c = CH_CR;
				3: c = CH_LF;
				default: c = 8'($urandom_range(255));
			endcase
			send_char(c);
			// a quote inside a cell goes out doubled
			if (c == CH_QUOTE)
				send_char(c);
		end
	endtask

	task automatic send_cell(input logic last);
		if ($urandom_range(9) == 0)
			send_char(CH_CR);
		send_char(CH_QUOTE);
		send_content();
		send_char(CH_QUOTE);
		if ($urandom_range(9) == 0)
			send_char(CH_CR);
		send_char(last ? CH_LF : CH_COMMA);
	endtask

	task automatic send_row();
		int unsigned cells;
		cells = $urandom_range(4);
		if (cells == 0) begin
			if ($urandom_range(3) == 0)
				send_char(CH_CR);
			send_char(CH_LF);
		end else begin
			for (int unsigned i = 0; i < cells; i++)
				send_cell(i == cells - 1);
		end
	endtask

	// Receiver: stall at the current rate, beat by beat.
	always @(posedge clk) begin
		token_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Score both channels at each edge and watch for a hang.
	always @(posedge clk) begin
		byte_note_t note;
		token_t     predicted;
		token_t     want;
		logic       hit;
		logic       moved;
		if (arst_n) begin
			moved = 1'b0;
			if (byte_valid && byte_ready) begin
				moved = 1'b1;
				note = byte_notes.pop_front();
				hit = tokenize_byte(byte_in, predicted);
				if (note.fixed)
					pending_tokens.insert(pending_tokens.size(), note.tok);
				else if (hit)
					pending_tokens.insert(pending_tokens.size(), predicted);
			end
			if (token_valid && token_ready) begin
				moved = 1'b1;
				if (pending_tokens.size() == 0) begin
					fail_count++;
					$error("token with nothing expected: kind %0d, byte 0x%0h, line %0d",
						token_kind, cell_byte, line_number);
				end else begin
					want = pending_tokens.pop_front();
					check_field("token_kind", 32'(want.kind), 32'(token_kind));
					check_field("cell_byte", 32'(want.data), 32'(cell_byte));
					check_field("line_number", 32'(want.line), 32'(line_number));
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int unsigned phase_start;
		logic [7:0]  stray;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// First phase: sender idles lightly, receiver stalls heavily.
		send_idle_pct = 11;
		recv_idle_pct = 53;
		foreach (directed_rows[i])
			drive_byte(directed_rows[i]);

		// Hold the sender until every token so far has drained.
		byte_valid <= 1'b0;
		do @(posedge clk); while (pending_tokens.size() != 0);

		phase_start = sent_beats;
		while (sent_beats - phase_start < PHASE_BEATS)
			send_row();

		// Second phase: roles swapped.
		send_idle_pct = 53;
		recv_idle_pct = 11;
		phase_start = sent_beats;
		while (sent_beats - phase_start < PHASE_BEATS)
			send_row();

		// Third phase: no idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		phase_start = sent_beats;
		while (sent_beats - phase_start < PHASE_BEATS)
			send_row();

		// Break the text with a stray byte outside quotes, leaving the row unfinished.
		if ($urandom_range(1)) begin
			repeat ($urandom_range(2))
				send_cell(1'b0);
			do stray = 8'($urandom_range(255));
			while (stray == CH_QUOTE || stray == CH_CR || stray == CH_LF);
		end else begin
			send_char(CH_QUOTE);
			send_content();
			send_char(CH_QUOTE);
			do stray = 8'($urandom_range(255));
			while (stray == CH_QUOTE || stray == CH_COMMA || stray == CH_CR || stray == CH_LF);
		end
		send_char(stray);
		// The error sticks: every later byte, newlines too, reports the same line.
		repeat (16)
			send_char(($urandom_range(3) == 0) ? CH_LF : 8'($urandom_range(255)));

		byte_valid <= 1'b0;
		do @(posedge clk); while (pending_tokens.size() != 0);
		// Allow for the two-register pipeline, so a stray late token is caught.
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
